>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mailbox core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/mqm_pkg.sv
// ----------------------------------------------------------------------------
// mqm_pkg
// Types, sizes and codes shared by the mailbox core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mqm_pkg;

  localparam int NUM_QUEUES  = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int FIFO_DEPTH  = 2;

  localparam int QID_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int USER_W  = 16;
  localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W   = $clog2(2 * QUEUE_DEPTH);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int FPTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_GET   = 2'd0,
    FUNC_CLOSE = 2'd1,
    FUNC_SEND  = 2'd2,
    FUNC_RECV  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ERR   = 2'd1,
    STAT_BLOCK = 2'd2
  } status_t;

  localparam logic [1:0] OPT_CREATE  = 2'd0;
  localparam logic [1:0] OPT_EXCL    = 2'd1;
  localparam logic [1:0] OPT_WAIT    = 2'd0;
  localparam logic [1:0] OPT_NOWAIT  = 2'd1;
  localparam logic [1:0] OPT_NOERROR = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_RECV
  } back_state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [QID_W-1:0]  queue_id;
    logic [1:0]        option;
    logic [BYTE_W-1:0] msg_byte;
    logic [BYTE_W-1:0] max_count;
  } in_req_t;

  typedef struct packed {
    status_t           status;
    logic [QID_W-1:0]  ret_queue;
    logic              has_data;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_rsp_t;

  typedef struct packed {
    func_t             op;
    logic              qid_ok;
    logic [QIDX_W-1:0] qidx;
    logic [QID_W-1:0]  queue_id;
    logic [1:0]        option;
    logic [BYTE_W-1:0] msg_byte;
    logic [BYTE_W-1:0] max_count;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } fifo_wr_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } fifo_rd_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/mqm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mqm_cmd_fifo
// Short command queue between the request decoder and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module mqm_cmd_fifo
  import mqm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire cmd_t         push_cmd,
  output fifo_wr_ctl_t      wr_stat,
  input  wire logic         pop,
  output cmd_t              pop_cmd,
  output fifo_rd_ctl_t      rd_stat
);

  cmd_t              slot_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;
  logic              full, empty, do_push, do_pop;

  assign full    = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd       = slot_r[rd_ptr_r];
  assign wr_stat.push  = do_push;
  assign wr_stat.full  = full;
  assign rd_stat.pop   = do_pop;
  assign rd_stat.empty = empty;

endmodule

`default_nettype wire

>>> hw/rtl/mqm_front.sv
// ----------------------------------------------------------------------------
// mqm_front
// Request intake: accept, range-check and decode one mailbox request.
// ----------------------------------------------------------------------------
`default_nettype none

module mqm_front
  import mqm_pkg::*;
(
  input  wire logic    start,
  input  wire in_req_t in_req,
  input  wire logic    fifo_full,
  output logic         busy,
  output logic         push,
  output cmd_t         cmd
);

  assign busy = fifo_full;
  assign push = start && !fifo_full;

  always_comb begin
    cmd.op        = func_t'(in_req.func);
    cmd.qid_ok    = (int'(in_req.queue_id) < NUM_QUEUES);
    cmd.qidx      = QIDX_W'(in_req.queue_id);
    cmd.queue_id  = in_req.queue_id;
    cmd.option    = in_req.option;
    cmd.msg_byte  = in_req.msg_byte;
    cmd.max_count = in_req.max_count;
  end

endmodule

`default_nettype wire

>>> hw/rtl/mqm_back.sv
// ----------------------------------------------------------------------------
// mqm_back
// Executor: queue state, byte store and result generation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mqm_back
  import mqm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cmd_t         fifo_cmd,
  input  wire fifo_rd_ctl_t fifo_stat,
  output logic              pop,
  output logic              out_valid,
  output out_rsp_t          out_rsp
);

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_r, out_nxt;

  logic [USER_W-1:0] user_cnt_r [NUM_QUEUES];
  logic [CNT_W-1:0]  q_cnt_r    [NUM_QUEUES];
  logic [HEAD_W-1:0] q_head_r   [NUM_QUEUES];

  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr, base;
  logic              mem_we;

  logic              upd_user, upd_cnt, upd_head;
  logic [USER_W-1:0] user_val;
  logic [CNT_W-1:0]  cnt_val, take, head_inc;
  logic [HEAD_W-1:0] head_val, head_next;
  logic [POS_W-1:0]  pos;
  logic [USER_W-1:0] user_cur;
  logic [CNT_W-1:0]  cnt_cur;
  logic [HEAD_W-1:0] head_cur;
  logic              over;

  assign user_cur = user_cnt_r[cmd_r.qidx];
  assign cnt_cur  = q_cnt_r[cmd_r.qidx];
  assign head_cur = q_head_r[cmd_r.qidx];
  assign base     = ADDR_W'(cmd_r.qidx) * ADDR_W'(QUEUE_DEPTH);

  always_comb begin
    pos = POS_W'(head_cur) + POS_W'(cnt_cur);
    if (pos >= POS_W'(QUEUE_DEPTH)) begin
      pos = pos - POS_W'(QUEUE_DEPTH);
    end
    head_inc = CNT_W'(head_cur) + 1'b1;
    if (head_inc == CNT_W'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
    head_next = HEAD_W'(head_inc);
    over = (int'(cnt_cur) > int'(cmd_r.max_count));
    take = over ? CNT_W'(cmd_r.max_count) : cnt_cur;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    remain_nxt    = remain_r;
    pop           = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.last  = 1'b1;
    mem_we        = 1'b0;
    wr_addr       = base + ADDR_W'(pos);
    rd_addr       = base + ADDR_W'(head_cur);
    upd_user      = 1'b0;
    user_val      = user_cur;
    upd_cnt       = 1'b0;
    cnt_val       = cnt_cur;
    upd_head      = 1'b0;
    head_val      = head_next;
    case (state_r)
      BK_IDLE: begin
        if (!fifo_stat.empty) begin
          pop       = 1'b1;
          cmd_nxt   = fifo_cmd;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_nxt     = BK_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt.status = STAT_ERR;
        if (cmd_r.qid_ok) begin
          case (cmd_r.op)
            FUNC_GET: begin
              if (cmd_r.option == OPT_CREATE ||
                  (cmd_r.option == OPT_EXCL && user_cur == '0)) begin
                out_nxt.status    = STAT_OK;
                out_nxt.ret_queue = cmd_r.queue_id;
                if (user_cur != '1) begin
                  upd_user = 1'b1;
                  user_val = user_cur + 1'b1;
                end
              end
            end
            FUNC_CLOSE: begin
              if (user_cur != '0) begin
                out_nxt.status = STAT_OK;
                upd_user       = 1'b1;
                user_val       = user_cur - 1'b1;
              end
            end
            FUNC_SEND: begin
              if (cnt_cur != CNT_W'(QUEUE_DEPTH)) begin
                out_nxt.status = STAT_OK;
                mem_we         = 1'b1;
                upd_cnt        = 1'b1;
                cnt_val        = cnt_cur + 1'b1;
              end else if (cmd_r.option == OPT_WAIT) begin
                out_nxt.status = STAT_BLOCK;
              end
            end
            FUNC_RECV: begin
              if (cnt_cur == '0) begin
                out_nxt.status = (cmd_r.option == OPT_NOWAIT) ? STAT_ERR : STAT_BLOCK;
              end else if (over && cmd_r.option != OPT_NOERROR) begin
                out_nxt.status = STAT_ERR;
              end else if (take == '0) begin
                out_nxt.status = STAT_OK;
              end else begin
                out_valid_nxt = 1'b0;
                remain_nxt    = take;
                upd_cnt       = 1'b1;
                cnt_val       = cnt_cur - take;
                state_nxt     = BK_RECV;
              end
            end
            default: begin
              out_nxt.status = STAT_ERR;
            end
          endcase
        end
      end
      BK_RECV: begin
        out_valid_nxt    = 1'b1;
        out_nxt.status   = STAT_OK;
        out_nxt.has_data = 1'b1;
        out_nxt.out_byte = rd_data_r;
        out_nxt.last     = (remain_r == CNT_W'(1));
        remain_nxt       = remain_r - 1'b1;
        upd_head         = 1'b1;
        rd_addr          = base + ADDR_W'(head_next);
        if (remain_r == CNT_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        user_cnt_r[i] <= '0;
        q_cnt_r[i]    <= '0;
        q_head_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd_user) begin
        user_cnt_r[cmd_r.qidx] <= user_val;
      end
      if (upd_cnt) begin
        q_cnt_r[cmd_r.qidx] <= cnt_val;
      end
      if (upd_head) begin
        q_head_r[cmd_r.qidx] <= head_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd_r.msg_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  `ASSERT_IMPL(a_recv_remain, clk, rst_n, state_r == BK_RECV, remain_r != '0)
  `ASSERT_IMPL(a_data_ok, clk, rst_n, out_valid_r && out_r.has_data, out_r.status == STAT_OK)
  `ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, !fifo_stat.empty && fifo_stat.pop)
  `ASSERT_NEXT(a_burst_cont, clk, rst_n, out_valid_r && !out_r.last, out_valid_r)

endmodule

`default_nettype wire

>>> hw/rtl/multi_queue_mailbox_core.sv
// ----------------------------------------------------------------------------
// multi_queue_mailbox_core
// Bank of byte mailboxes with per-queue user counts.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_req and raise start; the request is taken on a clock edge where
//   start is high and busy is low. busy rises only when the two-entry command
//   queue is full, so up to two requests can be posted ahead of execution.
//   Results come on out_rsp, qualified by out_valid for exactly one cycle;
//   the receiver must take them, there is no stall path.
//   Get, close and send give one result. A receive that takes bytes gives one
//   result per byte on consecutive cycles, with last on the final byte;
//   all other cases give one result with last set.
//   A request is written into the command queue, popped into the executor
//   when it is idle, and its result is registered onto out_rsp/out_valid.
//   The executor takes one request at a time: it fetches it from the command
//   queue, acts on queue state, then returns any received bytes through the
//   registered byte store read port; only then does it pop the next request.
//   Reset (rst_n low, synchronous) empties all queues, clears user counts and
//   the command queue; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_mailbox_core
  import mqm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire in_req_t in_req,
  output logic         out_valid,
  output out_rsp_t     out_rsp
);

  logic         push, pop;
  cmd_t         push_cmd, pop_cmd;
  fifo_wr_ctl_t wr_stat;
  fifo_rd_ctl_t rd_stat;

  mqm_front u_front (
    .start     (start),
    .in_req    (in_req),
    .fifo_full (wr_stat.full),
    .busy      (busy),
    .push      (push),
    .cmd       (push_cmd)
  );

  mqm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .wr_stat  (wr_stat),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .rd_stat  (rd_stat)
  );

  mqm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_cmd  (pop_cmd),
    .fifo_stat (rd_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire
